// ===== rtl/krt_pkg.sv =====
// Shared types and constants for the keyed record table.
`timescale 1ns / 1ps

package krt_pkg;

    // Field widths
    localparam int KEY_W  = 31;
    localparam int VAL_W  = 32;
    localparam int WORD_W = 1 + KEY_W + VAL_W;

    // Stored word layout: {live, key, value}
    localparam int LIVE_BIT = WORD_W - 1;
    localparam int KEY_LSB  = VAL_W;

    // Request codes
    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_UPDATE = 3'd1;
    localparam logic [2:0] REQ_REMOVE = 3'd2;
    localparam logic [2:0] REQ_SEARCH = 3'd3;
    localparam logic [2:0] REQ_COUNT  = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DUP     = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // Scan outcome flags handed from the scanner to the controller
    typedef struct packed {
        logic hit;   // a live slot holds the requested key
        logic hole;  // a freed slot exists below the high-water mark
    } scan_flags_t;

endpackage

// ===== rtl/krt_mem.sv =====
// Slot store: one synchronous RAM holding {live, key, value} per slot.
`timescale 1ns / 1ps

module krt_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic [krt_pkg::WORD_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic [krt_pkg::WORD_W-1:0] rd_data
);

    logic [krt_pkg::WORD_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/krt_scan.sv =====
// Key scanner: compares each word read back against the request key.
`timescale 1ns / 1ps

module krt_scan #(
    parameter int AW = 6
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  logic                       issue,
    input  logic [AW-1:0]              issue_idx,
    input  logic [krt_pkg::WORD_W-1:0] rd_word,
    input  logic [krt_pkg::KEY_W-1:0]  key,
    output krt_pkg::scan_flags_t       flags,
    output logic [AW-1:0]              hit_idx,
    output logic [AW-1:0]              hole_idx
);

    logic                 valid_reg;
    logic [AW-1:0]        idx_reg;
    krt_pkg::scan_flags_t flags_reg;
    krt_pkg::scan_flags_t flags_next;
    logic [AW-1:0]        hit_idx_reg;
    logic [AW-1:0]        hit_idx_next;
    logic [AW-1:0]        hole_idx_reg;
    logic [AW-1:0]        hole_idx_next;
    logic                 word_live;
    logic [krt_pkg::KEY_W-1:0] word_key;

    assign word_live = rd_word[krt_pkg::LIVE_BIT];
    assign word_key  = rd_word[krt_pkg::KEY_LSB +: krt_pkg::KEY_W];

    // Track first live match and lowest freed slot
    always_comb
    begin
        flags_next    = flags_reg;
        hit_idx_next  = hit_idx_reg;
        hole_idx_next = hole_idx_reg;
        if (clear)
        begin
            flags_next = '0;
        end
        else if (valid_reg)
        begin
            if (word_live && (word_key == key) && !flags_reg.hit)
            begin
                flags_next.hit = 1'b1;
                hit_idx_next   = idx_reg;
            end
            if (!word_live && !flags_reg.hole)
            begin
                flags_next.hole = 1'b1;
                hole_idx_next   = idx_reg;
            end
        end
    end

    // Read-data valid tracking and flag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            flags_reg <= '0;
        end
        else
        begin
            valid_reg <= issue;
            flags_reg <= flags_next;
        end
    end

    // Index payload
    always_ff @(posedge clk)
    begin
        idx_reg      <= issue_idx;
        hit_idx_reg  <= hit_idx_next;
        hole_idx_reg <= hole_idx_next;
    end

    assign flags    = flags_reg;
    assign hit_idx  = hit_idx_reg;
    assign hole_idx = hole_idx_reg;

endmodule

// ===== rtl/keyed_record_table.sv =====
// Top level of the keyed record table: request sequencer around the slot RAM.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. Insert, update,
// remove and search read every slot below the high-water mark out of the
// slot RAM, one per cycle, then let the last word land in the scanner and
// make the decision and the write-back; the result appears on status,
// slot and live_count for exactly one cycle with done high. Count and
// undefined request codes need no scan and go straight to the decision.
// The sequential key scan over the single RAM read port sets the time to
// a result. A new request may be issued in the cycle in which done is
// high. The result must be captured when done is high; it is held on the
// outputs until the next request's decision. No clearing pass is needed
// after reset: slots at or above the high-water mark are never read.
module keyed_record_table #(
    parameter int CAPACITY = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [2:0]         req_type,
    input  logic [30:0]        rec_id,
    input  logic signed [31:0] rec_value,
    output logic               busy,
    output logic               done,
    output logic [1:0]         status,
    output logic [5:0]         slot,
    output logic [6:0]         live_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic [2:0]                 req_reg;
    logic [krt_pkg::KEY_W-1:0]  key_reg;
    logic [krt_pkg::VAL_W-1:0]  val_reg;
    logic [CW-1:0]              hw_reg;
    logic [CW-1:0]              hw_next;
    logic [CW-1:0]              live_reg;
    logic [CW-1:0]              live_next;
    logic [CW-1:0]              cnt_reg;
    logic [CW-1:0]              cnt_next;
    logic                       done_reg;
    logic [1:0]                 status_reg;
    logic [1:0]                 status_next;
    logic [5:0]                 slot_reg;
    logic [5:0]                 slot_next;
    logic [6:0]                 count_reg;
    logic [6:0]                 count_next;

    logic                       accept;
    logic                       issue;
    logic                       scan_op;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [krt_pkg::WORD_W-1:0] wr_word;
    logic [krt_pkg::WORD_W-1:0] rd_word;
    logic [AW-1:0]              res_idx;
    logic [AW+5:0]              slot_ext;
    logic [CW+6:0]              count_ext;
    krt_pkg::scan_flags_t       flags;
    logic [AW-1:0]              hit_idx;
    logic [AW-1:0]              hole_idx;

    assign accept  = start && (state_reg == S_IDLE);
    assign issue   = (state_reg == S_SCAN) && (cnt_reg < hw_reg);
    assign scan_op = req_type inside {krt_pkg::REQ_INSERT, krt_pkg::REQ_UPDATE,
                                      krt_pkg::REQ_REMOVE, krt_pkg::REQ_SEARCH};

    krt_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_word),
        .rd_en   (issue),
        .rd_addr (cnt_reg[AW-1:0]),
        .rd_data (rd_word)
    );

    krt_scan #(
        .AW (AW)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (accept),
        .issue     (issue),
        .issue_idx (cnt_reg[AW-1:0]),
        .rd_word   (rd_word),
        .key       (key_reg),
        .flags     (flags),
        .hit_idx   (hit_idx),
        .hole_idx  (hole_idx)
    );

    // Decision and write-back
    always_comb
    begin
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_word     = '0;
        status_next = krt_pkg::ST_OK;
        res_idx     = '0;
        hw_next     = hw_reg;
        live_next   = live_reg;
        if (state_reg == S_DECIDE)
        begin
            case (req_reg)
                krt_pkg::REQ_INSERT:
                begin
                    if (flags.hit)
                    begin
                        status_next = krt_pkg::ST_DUP;
                    end
                    else if (flags.hole)
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = hole_idx;
                        wr_word   = {1'b1, key_reg, val_reg};
                        res_idx   = hole_idx;
                        live_next = live_reg + CW'(1);
                    end
                    else if (hw_reg < CW'(CAPACITY))
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = hw_reg[AW-1:0];
                        wr_word   = {1'b1, key_reg, val_reg};
                        res_idx   = hw_reg[AW-1:0];
                        hw_next   = hw_reg + CW'(1);
                        live_next = live_reg + CW'(1);
                    end
                    else
                    begin
                        status_next = krt_pkg::ST_FULL;
                    end
                end
                krt_pkg::REQ_UPDATE, krt_pkg::REQ_REMOVE, krt_pkg::REQ_SEARCH:
                begin
                    if (!flags.hit)
                    begin
                        status_next = krt_pkg::ST_MISSING;
                    end
                    else
                    begin
                        res_idx = hit_idx;
                        wr_addr = hit_idx;
                        if (req_reg == krt_pkg::REQ_UPDATE)
                        begin
                            wr_en   = 1'b1;
                            wr_word = {1'b1, key_reg, val_reg};
                        end
                        else if (req_reg == krt_pkg::REQ_REMOVE)
                        begin
                            // freed slot keeps its key but never matches
                            wr_en     = 1'b1;
                            wr_word   = {1'b0, key_reg, {krt_pkg::VAL_W{1'b0}}};
                            live_next = live_reg - CW'(1);
                        end
                    end
                end
                default:
                begin
                    // count and undefined codes leave the table untouched
                end
            endcase
        end
    end

    // Result fields wrap to their port widths
    assign slot_ext   = {6'b0, res_idx};
    assign slot_next  = slot_ext[5:0];
    assign count_ext  = {7'b0, live_next};
    assign count_next = count_ext[6:0];

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cnt_next   = '0;
                    state_next = scan_op ? S_SCAN : S_DECIDE;
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, table counters and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            hw_reg     <= '0;
            live_reg   <= '0;
            done_reg   <= 1'b0;
            status_reg <= krt_pkg::ST_OK;
            slot_reg   <= '0;
            count_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            hw_reg    <= hw_next;
            live_reg  <= live_next;
            done_reg  <= (state_reg == S_DECIDE);
            if (state_reg == S_DECIDE)
            begin
                status_reg <= status_next;
                slot_reg   <= slot_next;
                count_reg  <= count_next;
            end
        end
    end

    // Request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_type;
            key_reg <= rec_id;
            val_reg <= rec_value;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign status     = status_reg;
    assign slot       = slot_reg;
    assign live_count = count_reg;

endmodule

// ===== rtl/krt_check.sv =====
// Port-level checks for the keyed record table, bound to the top level.
`timescale 1ns / 1ps

module krt_check (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [1:0] status,
    input logic [5:0] slot
);

    // An accepted request keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // Result strobe only while idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // Each request ends with a result
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("request finished without a result");

    // Strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // Failed requests report slot zero
    a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != krt_pkg::ST_OK)) |-> (slot == 6'd0))
        else $error("non-zero slot on failed request");

endmodule

bind keyed_record_table krt_check u_krt_check (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .status (status),
    .slot   (slot)
);
